// ===== hdl/circular_byte_buffer_unit_assert.svh =====
// Assertion macros for the checker module of the byte ring buffer.
// Each macro expects clk and rst_n in scope and reports through $error.
`ifndef CIRCULAR_BYTE_BUFFER_UNIT_ASSERT_SVH
`define CIRCULAR_BYTE_BUFFER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CBB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CBB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cbb_pkg.sv =====
// Package for the byte ring buffer: sizes, operation and status codes,
// and the structs used by the index control and the byte store.
package cbb_pkg;

  localparam int DEPTH      = 256;
  localparam int INDEX_BITS = 32;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int POS_BITS   = 32;
  localparam int OUT_BITS   = 32;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;

  localparam idx_t IDX_DEPTH = idx_t'(DEPTH);
  // Both indices come out of reset at minus 500.
  localparam idx_t IDX_RESET = idx_t'(0) - idx_t'(500);

  typedef enum logic [2:0] {
    MODE_PUSH      = 3'd0,
    MODE_POP       = 3'd1,
    MODE_WRITE     = 3'd2,
    MODE_READ      = 3'd3,
    MODE_SET_START = 3'd4,
    MODE_SET_END   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BLOCK = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]          mode;
    logic [7:0]          data_in;
    logic                overwrite;
    logic [POS_BITS-1:0] position;
  } item_t;

  typedef struct packed {
    logic       we;
    logic       re;
    addr_t      addr;
    logic [7:0] wdata;
  } mem_req_t;

  typedef struct packed {
    status_t             status;
    logic                rd_sel;
    logic [OUT_BITS-1:0] start_index;
    logic [OUT_BITS-1:0] end_index;
  } res_t;

endpackage

// ===== hdl/cbb_in_if.sv =====
// Input and result channel interfaces of the byte ring buffer.
// Depends on cbb_pkg for the field widths.
interface cbb_in_if
  import cbb_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [2:0]          mode;
  logic [7:0]          data_in;
  logic                overwrite;
  logic [POS_BITS-1:0] position;
  logic                final_byte;

  modport source (output valid, mode, data_in, overwrite, position, final_byte,
                  input ready);
  modport sink (input valid, mode, data_in, overwrite, position, final_byte,
                output ready);
endinterface

interface cbb_out_if
  import cbb_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [7:0]          data_out;
  logic [OUT_BITS-1:0] start_index;
  logic [OUT_BITS-1:0] end_index;
  logic                last;

  modport source (output valid, status, data_out, start_index, end_index, last,
                  input ready);
  modport sink (input valid, status, data_out, start_index, end_index, last,
                output ready);
endinterface

// ===== hdl/cbb_store.sv =====
// Byte store of the ring buffer: one write or one registered read per cycle.
// Depends on cbb_pkg for the depth and the request struct.
module cbb_store
  import cbb_pkg::*;
(
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/cbb_ctrl.sv =====
// Index control of the byte ring buffer: holds head and tail, decodes the
// operation, issues the store request and forms the result. Uses cbb_pkg.
module cbb_ctrl
  import cbb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  item_t    item,
  output mem_req_t mem_req,
  output res_t     res
);

  idx_t head_r, head_nxt;
  idx_t tail_r, tail_nxt;
  idx_t pos;
  idx_t cnt;
  idx_t off;
  idx_t span;
  logic full;
  logic in_win;
  logic at_tail;
  status_t status;
  logic we, re;
  addr_t addr;

  assign pos     = idx_t'(item.position);
  assign cnt     = tail_r - head_r;
  assign off     = pos - head_r;
  assign span    = tail_r - pos;
  assign full    = cnt >= IDX_DEPTH;
  assign in_win  = off <= cnt;
  assign at_tail = pos == tail_r;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    status   = ST_OK;
    we       = 1'b0;
    re       = 1'b0;
    addr     = pos[ADDR_BITS-1:0];
    unique case (item.mode)
      MODE_PUSH: begin
        addr = tail_r[ADDR_BITS-1:0];
        if (!item.overwrite && full) begin
          status = ST_BLOCK;
        end else begin
          we       = 1'b1;
          tail_nxt = tail_r + idx_t'(1);
          // drop the oldest byte
          if (full) head_nxt = head_r + idx_t'(1);
        end
      end
      MODE_POP: begin
        addr = head_r[ADDR_BITS-1:0];
        if (cnt == '0) begin
          status = ST_BLOCK;
        end else begin
          re       = 1'b1;
          head_nxt = head_r + idx_t'(1);
        end
      end
      MODE_WRITE: begin
        if (!in_win) begin
          status = ST_RANGE;
        end else begin
          we = 1'b1;
          if (at_tail) begin
            tail_nxt = pos + idx_t'(1);
            if (full) head_nxt = head_r + idx_t'(1);
          end
        end
      end
      MODE_READ: begin
        if (!in_win || at_tail) begin
          status = ST_RANGE;
        end else begin
          re = 1'b1;
        end
      end
      MODE_SET_START: begin
        head_nxt = (span > IDX_DEPTH) ? tail_r - IDX_DEPTH : pos;
      end
      MODE_SET_END: begin
        tail_nxt = (off > IDX_DEPTH) ? head_r + IDX_DEPTH : pos;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= IDX_RESET;
      tail_r <= IDX_RESET;
    end else if (accept) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  assign mem_req.we    = accept && we;
  assign mem_req.re    = accept && re;
  assign mem_req.addr  = addr;
  assign mem_req.wdata = item.data_in;

  assign res.status      = status;
  assign res.rd_sel      = re;
  assign res.start_index = head_nxt[OUT_BITS-1:0];
  assign res.end_index   = tail_nxt[OUT_BITS-1:0];

endmodule

// ===== hdl/circular_byte_buffer_unit.sv =====
// Byte ring buffer with overwrite. Latency: a result is valid in the cycle
// after its input transfer. Throughput: one item per cycle while the sink
// takes results, set by the head/tail update loop and the one-port byte store.
// Reset (rst_n, synchronous, active low) sets both indices to minus 500 and
// empties the result register; the byte store is not cleared.
module circular_byte_buffer_unit
  import cbb_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  cbb_in_if.sink   in_if,
  cbb_out_if.source out_if
);

  item_t    item;
  mem_req_t mem_req;
  res_t     res;
  logic     accept;
  logic [7:0] rd_data;

  logic       out_vld_r;
  res_t       res_r;
  logic       last_r;

  assign in_if.ready = !out_vld_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  assign item.mode      = in_if.mode;
  assign item.data_in   = in_if.data_in;
  assign item.overwrite = in_if.overwrite;
  assign item.position  = in_if.position;

  cbb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .item    (item),
    .mem_req (mem_req),
    .res     (res)
  );

  cbb_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (accept) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // hold the result while the sink stalls
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r  <= res;
      last_r <= in_if.final_byte;
    end
  end

  assign out_if.valid       = out_vld_r;
  assign out_if.status      = res_r.status;
  assign out_if.data_out    = res_r.rd_sel ? rd_data : 8'd0;
  assign out_if.start_index = res_r.start_index;
  assign out_if.end_index   = res_r.end_index;
  assign out_if.last        = last_r;

endmodule

// ===== hdl/cbb_checker.sv =====
// Port-level checker for the byte ring buffer, bound to the top level.
// Uses cbb_pkg and the macros of circular_byte_buffer_unit_assert.svh.
`include "circular_byte_buffer_unit_assert.svh"

module cbb_checker
  import cbb_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [1:0]          out_status,
  input logic [7:0]          out_data_out,
  input logic [OUT_BITS-1:0] out_start_index,
  input logic [OUT_BITS-1:0] out_end_index
);

  logic [OUT_BITS-1:0] held;

  assign held = out_end_index - out_start_index;

  `CBB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `CBB_ASSERT_NEXT(a_in_to_out, in_valid && in_ready, out_valid, "transfer gave no result")
  `CBB_ASSERT_NOW(a_count_max, out_valid, held <= OUT_BITS'(DEPTH), "held count above depth")
  `CBB_ASSERT_NOW(a_fail_zero, out_valid && out_status != ST_OK, out_data_out == 8'd0, "failed op returned data")

endmodule

bind circular_byte_buffer_unit cbb_checker u_cbb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_status      (out_if.status),
  .out_data_out    (out_if.data_out),
  .out_start_index (out_if.start_index),
  .out_end_index   (out_if.end_index)
);

// ===== tb/sv/tb_circular_byte_buffer_unit.sv =====
// Self-checking testbench for circular_byte_buffer_unit: directed and random byte operations,
// with results checked against a ring model kept in the bench.
// Depends on cbb_pkg and the cbb_in_if / cbb_out_if interfaces.
module tb_circular_byte_buffer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import cbb_pkg::*;

  localparam logic [2:0]  MODE_SPARE_LO = 3'd6;
  localparam logic [2:0]  MODE_SPARE_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam int unsigned MAX_REPORTS   = 40;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data;
    logic       ovw;
    idx_t       pos;
    logic       fin;
  } ring_req_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] data_out;
    idx_t       start_index;
    idx_t       end_index;
    logic       last;
  } ring_rsp_t;

  logic clk;
  logic rst_n;

  cbb_in_if  in_if();
  cbb_out_if out_if();

  circular_byte_buffer_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // Ring model state
  idx_t       ring_head;
  idx_t       ring_tail;
  logic [7:0] ring_bytes [DEPTH];
  bit         ring_written [DEPTH];

  ring_rsp_t   pending_results[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;
  int unsigned results_seen;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic idx_t ring_count();
    return ring_tail - ring_head;
  endfunction

  // true when p lies in head..tail inclusive
  function automatic bit ring_holds(idx_t p);
    idx_t off;
    off = p - ring_head;
    return off <= ring_count();
  endfunction

  function automatic void clamp_head();
    if (ring_count() > IDX_DEPTH) ring_head = ring_tail - IDX_DEPTH;
  endfunction

  function automatic void clamp_tail();
    if (ring_count() > IDX_DEPTH) ring_tail = ring_head + IDX_DEPTH;
  endfunction

  function automatic void store_byte(idx_t p, logic [7:0] b);
    ring_bytes[addr_t'(p)]   = b;
    ring_written[addr_t'(p)] = 1'b1;
  endfunction

  // Apply one operation to the ring model and return the result it yields.
  function automatic ring_rsp_t compute_ring_result(ring_req_t r);
    ring_rsp_t rsp;
    rsp.status   = ST_OK;
    rsp.data_out = 8'h00;
    rsp.last     = r.fin;
    case (r.mode)
      MODE_PUSH: begin
        if (!r.ovw && ring_count() >= IDX_DEPTH) begin
          rsp.status = ST_BLOCK;
        end else begin
          store_byte(ring_tail, r.data);
          ring_tail = ring_tail + 1;
          clamp_head();
        end
      end
      MODE_POP: begin
        if (ring_count() == 0) begin
          rsp.status = ST_BLOCK;
        end else begin
          rsp.data_out = ring_bytes[addr_t'(ring_head)];
          ring_head    = ring_head + 1;
        end
      end
      MODE_WRITE: begin
        if (!ring_holds(r.pos)) begin
          rsp.status = ST_RANGE;
        end else begin
          if (r.pos == ring_tail) begin
            ring_tail = r.pos + 1;
            clamp_head();
          end
          store_byte(r.pos, r.data);
        end
      end
      MODE_READ: begin
        if (!ring_holds(r.pos) || r.pos == ring_tail) rsp.status = ST_RANGE;
        else rsp.data_out = ring_bytes[addr_t'(r.pos)];
      end
      MODE_SET_START: begin
        ring_head = r.pos;
        clamp_head();
      end
      MODE_SET_END: begin
        ring_tail = r.pos;
        clamp_tail();
      end
      default: begin
      end
    endcase
    rsp.start_index = ring_head;
    rsp.end_index   = ring_tail;
    return rsp;
  endfunction

  // A pop or read that would return a never-written byte is outside the contract.
  function automatic bit hits_unwritten(ring_req_t r);
    if (r.mode == MODE_POP)
      return ring_count() != 0 && !ring_written[addr_t'(ring_head)];
    if (r.mode == MODE_READ)
      return ring_holds(r.pos) && r.pos != ring_tail && !ring_written[addr_t'(r.pos)];
    return 1'b0;
  endfunction

  function automatic ring_req_t make_req(logic [2:0] mode, logic [7:0] data, logic ovw,
                                         idx_t pos, logic fin);
    ring_req_t r;
    r.mode = mode;
    r.data = data;
    r.ovw  = ovw;
    r.pos  = pos;
    r.fin  = fin;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch at result %0d: %s", results_seen, what);
  endtask

  task automatic send_item(ring_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    if (hits_unwritten(r)) r.mode = MODE_PUSH;
    in_if.valid      <= 1'b1;
    in_if.mode       <= r.mode;
    in_if.data_in    <= r.data;
    in_if.overwrite  <= r.ovw;
    in_if.position   <= r.pos;
    in_if.final_byte <= r.fin;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(compute_ring_result(r));
  endtask

  always @(posedge clk) begin : check_results
    ring_rsp_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, status %0d data %02h",
                                  out_if.status, out_if.data_out));
      end else begin
        want = pending_results.pop_front();
        if (out_if.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_if.status, want.status));
        if (out_if.data_out !== want.data_out)
          report_mismatch($sformatf("data_out %02h, want %02h", out_if.data_out, want.data_out));
        if (out_if.start_index !== want.start_index)
          report_mismatch($sformatf("start_index %08h, want %08h",
                                    out_if.start_index, want.start_index));
        if (out_if.end_index !== want.end_index)
          report_mismatch($sformatf("end_index %08h, want %08h",
                                    out_if.end_index, want.end_index));
        if (out_if.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", out_if.last, want.last));
      end
    end
  end

  // Empty-buffer refusal, push, pop, and index writes/reads at the window edges.
  task automatic test_basic_ops();
    send_item(make_req(MODE_POP, 8'h00, 1'b0, 32'h0, 1'b1));
    send_item(make_req(MODE_READ, 8'h00, 1'b0, ring_tail, 1'b1));
    send_item(make_req(MODE_PUSH, 8'h00, 1'b0, 32'h0, 1'b0));
    send_item(make_req(MODE_PUSH, 8'hFF, 1'b0, 32'h0, 1'b1));
    send_item(make_req(MODE_POP, 8'h00, 1'b0, 32'h0, 1'b1));
    send_item(make_req(MODE_WRITE, 8'hA5, 1'b0, ring_tail, 1'b1));
    send_item(make_req(MODE_WRITE, 8'h11, 1'b0, ring_tail + 5, 1'b0));
    send_item(make_req(MODE_READ, 8'h00, 1'b0, ring_head, 1'b0));
    send_item(make_req(MODE_READ, 8'h00, 1'b0, ring_tail, 1'b1));
    send_item(make_req(MODE_WRITE, 8'h3C, 1'b0, ring_head, 1'b1));
  endtask

  // Clamp the end to make the buffer full, then refuse and overwrite.
  task automatic test_full_and_overwrite();
    send_item(make_req(MODE_SET_END, 8'h00, 1'b0, ring_head + 1000, 1'b1));
    send_item(make_req(MODE_PUSH, 8'h66, 1'b0, 32'h0, 1'b1));
    send_item(make_req(MODE_PUSH, 8'h5A, 1'b1, 32'h0, 1'b1));
    send_item(make_req(MODE_POP, 8'h00, 1'b1, 32'hFFFF_FFFF, 1'b1));
  endtask

  // Extreme positions, then walk the window across the index wrap.
  task automatic test_index_extremes();
    send_item(make_req(MODE_SET_START, 8'h00, 1'b0, 32'h0, 1'b0));
    send_item(make_req(MODE_SET_END, 8'h00, 1'b0, 32'hFFFF_FFFF, 1'b1));
    send_item(make_req(MODE_WRITE, 8'h81, 1'b0, 32'hFFFF_FFFF, 1'b1));
    send_item(make_req(MODE_READ, 8'h00, 1'b0, 32'h0, 1'b1));
    send_item(make_req(MODE_SET_END, 8'h00, 1'b0, ring_tail + 256, 1'b0));
    send_item(make_req(MODE_SET_START, 8'h00, 1'b0, ring_tail, 1'b1));
    send_item(make_req(MODE_PUSH, 8'h7E, 1'b0, 32'h0, 1'b1));
    send_item(make_req(MODE_READ, 8'h00, 1'b0, ring_head, 1'b1));
  endtask

  task automatic test_unused_modes();
    send_item(make_req(MODE_SPARE_LO, 8'hC3, 1'b1, 32'h1234_5678, 1'b0));
    send_item(make_req(MODE_SPARE_HI, 8'h3C, 1'b0, 32'hEDCB_A987, 1'b1));
  endtask

  function automatic idx_t pick_access_pos();
    int unsigned c;
    c = $urandom_range(99);
    if (c < 75) return ring_head + $urandom_range(0, ring_count());
    if (c < 85) return ring_head - $urandom_range(1, 3);
    if (c < 92) return ring_tail + $urandom_range(1, 3);
    return $urandom();
  endfunction

  function automatic idx_t pick_bound_pos(bit for_start);
    int unsigned c;
    c = $urandom_range(99);
    if (c < 80) begin
      if (for_start) return ring_tail - $urandom_range(0, DEPTH + 4);
      return ring_head + $urandom_range(0, DEPTH + 4);
    end
    if (c < 90) return (for_start ? ring_head : ring_tail) + $urandom_range(0, 6) - 3;
    return $urandom();
  endfunction

  // Mostly multi-byte transfers with random content; a few stray and garbled items.
  task automatic test_random_traffic(int unsigned in_pct, int unsigned out_pct,
                                     int unsigned n_items);
    int unsigned done;
    int unsigned sel;
    int unsigned len;
    int unsigned k;
    logic [2:0]  op;
    logic        ovw;
    idx_t        base;
    ring_req_t   r;
    send_idle_pct  = in_pct;
    recv_stall_pct = out_pct;
    done = 0;
    while (done < n_items) begin
      sel  = $urandom_range(99);
      len  = $urandom_range(1, 8);
      ovw  = 1'($urandom_range(1));
      base = pick_access_pos();
      if (sel < 35) op = MODE_PUSH;
      else if (sel < 55) op = MODE_POP;
      else if (sel < 67) op = MODE_WRITE;
      else if (sel < 82) op = MODE_READ;
      else begin
        len = 1;
        op  = 3'($urandom_range(7));
      end
      for (k = 0; k < len; k++) begin
        r = make_req(op, 8'($urandom()), ovw, base + k, k == len - 1);
        if (sel >= 82) begin
          r.fin = 1'($urandom_range(1));
          if (op == MODE_SET_START && sel < 94) r.pos = pick_bound_pos(1'b1);
          else if (op == MODE_SET_END && sel < 94) r.pos = pick_bound_pos(1'b0);
          else r.pos = $urandom();
        end
        send_item(r);
        done++;
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.mode       = MODE_PUSH;
    in_if.data_in    = 8'h00;
    in_if.overwrite  = 1'b0;
    in_if.position   = '0;
    in_if.final_byte = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    mismatch_count   = 0;
    results_seen     = 0;
    ring_head        = IDX_RESET;
    ring_tail        = IDX_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      ring_bytes[i]   = 8'h00;
      ring_written[i] = 1'b0;
    end

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_full_and_overwrite();
    test_index_extremes();
    test_unused_modes();
    test_random_traffic(0, 0, 200);
    test_random_traffic(49, 0, 200);
    test_random_traffic(0, 49, 200);
    test_random_traffic(27, 27, 200);

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
